/* hw/rtl/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared widths, command and register codes, and the types that travel
// between the modules of the Go-Back-N sender with FEC groups.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  // Port field widths
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned OFS_W     = 24;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned WIN_W     = 8;
  localparam int unsigned GRP_W     = 8;
  localparam int unsigned CREDIT_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // Internal offset width default
  localparam int unsigned OFFSET_BITS_DEF = 24;

  // Commands
  localparam logic [CMD_W-1:0] CMD_SEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_PAYLOAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEND_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEC_GROUP   = 2'd3;

  // Configuration reset values
  localparam logic [OFS_W-1:0] OBJECT_SIZE_RST = '0;
  localparam logic [LEN_W-1:0] SEG_PAYLOAD_RST = 16'd1024;
  localparam logic [WIN_W-1:0] SEND_WINDOW_RST = 8'd8;
  localparam logic [GRP_W-1:0] FEC_GROUP_RST   = 8'd4;

  // Segment kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FEC  = 1'b1;

  typedef struct packed {
    logic [OFS_W-1:0] object_size;
    logic [LEN_W-1:0] segment_payload;
    logic [WIN_W-1:0] send_window;
    logic [GRP_W-1:0] fec_group;
  } cfg_t;

  typedef struct packed {
    logic             emitted;
    logic             segment_kind;
    logic [OFS_W-1:0] segment_offset;
    logic [LEN_W-1:0] segment_length;
    logic             transmitted;
    logic [OFS_W-1:0] acked_base;
    logic             transfer_done;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/gbn_ifs.sv */
// ----------------------------------------------------------------------------
// gbn_ifs
// Valid/ready channel interfaces: command beats in, descriptor beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbn_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [gbn_pkg::CMD_W-1:0]       command;
  logic [gbn_pkg::OFS_W-1:0]       ack_offset;
  logic                            drop_segment;

  modport source (output valid, output command, output ack_offset,
                  output drop_segment, input ready);
  modport sink   (input valid, input command, input ack_offset,
                  input drop_segment, output ready);
endinterface

interface gbn_desc_if;
  logic                            valid;
  logic                            ready;
  logic                            emitted;
  logic                            segment_kind;
  logic [gbn_pkg::OFS_W-1:0]       segment_offset;
  logic [gbn_pkg::LEN_W-1:0]       segment_length;
  logic                            transmitted;
  logic [gbn_pkg::OFS_W-1:0]       acked_base;
  logic                            transfer_done;

  modport source (output valid, output emitted, output segment_kind,
                  output segment_offset, output segment_length,
                  output transmitted, output acked_base,
                  output transfer_done, input ready);
  modport sink   (input valid, input emitted, input segment_kind,
                  input segment_offset, input segment_length,
                  input transmitted, input acked_base,
                  input transfer_done, output ready);
endinterface

`default_nettype wire

/* hw/rtl/gbn_seq.sv */
// ----------------------------------------------------------------------------
// gbn_seq
// Window, group and offset state; computes one descriptor per command beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_seq #(
  parameter int unsigned OFFSET_BITS = gbn_pkg::OFFSET_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gbn_pkg::cfg_t               cfg,
  input  logic                        take,
  input  logic [gbn_pkg::CMD_W-1:0]   command,
  input  logic [gbn_pkg::OFS_W-1:0]   ack_offset,
  input  logic                        drop_segment,
  output gbn_pkg::res_t               res
);

  localparam int unsigned CW = (OFFSET_BITS > gbn_pkg::LEN_W) ? OFFSET_BITS
                                                               : gbn_pkg::LEN_W;

  logic [OFFSET_BITS-1:0]       next_offset, next_offset_next;
  logic [OFFSET_BITS-1:0]       base_offset, base_offset_next;
  logic [gbn_pkg::GRP_W-1:0]    group_count, group_count_next;
  logic [gbn_pkg::CREDIT_W-1:0] credits, credits_next;

  logic [OFFSET_BITS-1:0]       size_o, ack_o, left;
  logic [gbn_pkg::LEN_W-1:0]    pay_eff, data_len;
  logic                         full, has_data, send_data, send_fec;

  // Derive the segment length and send conditions
  always_comb begin
    size_o    = OFFSET_BITS'(cfg.object_size);
    ack_o     = OFFSET_BITS'(ack_offset);
    pay_eff   = (cfg.segment_payload == '0) ? gbn_pkg::LEN_W'(1) : cfg.segment_payload;
    full      = group_count >= cfg.fec_group;
    has_data  = next_offset < size_o;
    left      = size_o - next_offset;
    data_len  = (CW'(pay_eff) > CW'(left)) ? gbn_pkg::LEN_W'(left) : pay_eff;
    send_data = (credits != '0) && !full && has_data;
    send_fec  = (credits != '0) && !send_data && (group_count != '0)
                && (full || !has_data);
  end

  // Next state and result for the current beat
  always_comb begin
    next_offset_next = next_offset;
    base_offset_next = base_offset;
    group_count_next = group_count;
    credits_next     = credits;
    res              = '0;
    unique case (command)
      gbn_pkg::CMD_SEND: begin
        if (send_data) begin
          res.emitted        = 1'b1;
          res.segment_kind   = gbn_pkg::KIND_DATA;
          res.segment_offset = gbn_pkg::OFS_W'(next_offset);
          res.segment_length = data_len;
          next_offset_next   = next_offset + OFFSET_BITS'(data_len);
          group_count_next   = group_count + 1'b1;
          credits_next       = credits - 1'b1;
        end else if (send_fec) begin
          res.emitted        = 1'b1;
          res.segment_kind   = gbn_pkg::KIND_FEC;
          res.segment_offset = gbn_pkg::OFS_W'(next_offset);
          res.segment_length = pay_eff;
          group_count_next   = '0;
          credits_next       = credits - 1'b1;
        end
      end
      gbn_pkg::CMD_ACK: begin
        if (ack_o > base_offset) begin
          base_offset_next = ack_o;
        end
        if (credits != '1) begin
          credits_next = credits + 1'b1;
        end
      end
      gbn_pkg::CMD_TIMEOUT: begin
        next_offset_next = base_offset;
        group_count_next = '0;
        credits_next     = gbn_pkg::CREDIT_W'(cfg.send_window);
      end
      gbn_pkg::CMD_START: begin
        next_offset_next = '0;
        base_offset_next = '0;
        group_count_next = '0;
        credits_next     = gbn_pkg::CREDIT_W'(cfg.send_window);
      end
      default: begin
      end
    endcase
    res.transmitted   = res.emitted && !drop_segment;
    res.acked_base    = gbn_pkg::OFS_W'(base_offset_next);
    res.transfer_done = base_offset_next >= size_o;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      next_offset <= '0;
      base_offset <= '0;
      group_count <= '0;
      credits     <= '0;
    end else if (take) begin
      next_offset <= next_offset_next;
      base_offset <= base_offset_next;
      group_count <= group_count_next;
      credits     <= credits_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/gbn_outq.sv */
// ----------------------------------------------------------------------------
// gbn_outq
// Two-entry result register with skid slot; decouples input from output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbn_pkg::res_t push_data,
  output logic          ready,
  output logic          valid,
  input  logic          pop_ready,
  output gbn_pkg::res_t head
);

  gbn_pkg::res_t q [2];
  logic [1:0]    count;
  logic          pop;

  assign pop   = valid && pop_ready;
  assign valid = count != 2'd0;
  assign ready = count != 2'd2;
  assign head  = q[0];

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Shift on pop, fill the first free slot on push
  always_ff @(posedge clk) begin
    priority if (push && pop) begin
      if (count == 2'd2) begin
        q[0] <= q[1];
        q[1] <= push_data;
      end else begin
        q[0] <= push_data;
      end
    end else if (pop) begin
      q[0] <= q[1];
    end else if (push) begin
      if (count == 2'd0) begin
        q[0] <= push_data;
      end else begin
        q[1] <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/go_back_n_sender_with_fec_groups.sv */
// ----------------------------------------------------------------------------
// go_back_n_sender_with_fec_groups
// Go-Back-N segment sequencer with one FEC segment per group of data segments.
// ----------------------------------------------------------------------------
//  channel  | dir | beat carries                                  | handshake
//  ---------+-----+-----------------------------------------------+-----------
//  cmd      | in  | command, ack_offset, drop_segment             | valid/ready
//  desc     | out | emitted, kind, offset, length, transmitted,   | valid/ready
//           |     | acked_base, transfer_done (one per cmd beat)  |
//  cfg      | in  | cfg_wr_en, cfg_index, cfg_wdata               | write only
//
//  One command beat per cycle while cmd.ready is high; its descriptor is
//  registered in the output queue on accept, and gbn_seq updates its state
//  on each accepted beat. A two-entry output register absorbs desc stall;
//  cmd.ready drops only when both entries hold results.
//  rst (synchronous) clears state and loads register defaults; credits start
//  at zero, so no segment is sent before a start, timeout or ack command.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_sender_with_fec_groups #(
  parameter int unsigned OFFSET_BITS = gbn_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  gbn_cmd_if.sink                         cmd,
  gbn_desc_if.source                      desc,
  input  logic                            cfg_wr_en,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gbn_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  gbn_pkg::cfg_t cfg;
  gbn_pkg::res_t res;
  gbn_pkg::res_t head;
  logic          take;
  logic          q_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.object_size     <= gbn_pkg::OBJECT_SIZE_RST;
      cfg.segment_payload <= gbn_pkg::SEG_PAYLOAD_RST;
      cfg.send_window     <= gbn_pkg::SEND_WINDOW_RST;
      cfg.fec_group       <= gbn_pkg::FEC_GROUP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        gbn_pkg::REG_OBJECT_SIZE: cfg.object_size     <= gbn_pkg::OFS_W'(cfg_wdata);
        gbn_pkg::REG_SEG_PAYLOAD: cfg.segment_payload <= gbn_pkg::LEN_W'(cfg_wdata);
        gbn_pkg::REG_SEND_WINDOW: cfg.send_window     <= gbn_pkg::WIN_W'(cfg_wdata);
        gbn_pkg::REG_FEC_GROUP:   cfg.fec_group       <= gbn_pkg::GRP_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  assign cmd.ready = q_ready;
  assign take      = cmd.valid && q_ready;

  gbn_seq #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .take         (take),
    .command      (cmd.command),
    .ack_offset   (cmd.ack_offset),
    .drop_segment (cmd.drop_segment),
    .res          (res)
  );

  gbn_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (res),
    .ready     (q_ready),
    .valid     (desc.valid),
    .pop_ready (desc.ready),
    .head      (head)
  );

  // Drive descriptor fields
  assign desc.emitted        = head.emitted;
  assign desc.segment_kind   = head.segment_kind;
  assign desc.segment_offset = head.segment_offset;
  assign desc.segment_length = head.segment_length;
  assign desc.transmitted    = head.transmitted;
  assign desc.acked_base     = head.acked_base;
  assign desc.transfer_done  = head.transfer_done;

endmodule

`default_nettype wire

/* hw/rtl/gbn_chk.sv */
// ----------------------------------------------------------------------------
// gbn_chk
// Port-level checks for the Go-Back-N sender, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_ready,
  input logic                        desc_valid,
  input logic                        desc_ready,
  input logic                        emitted,
  input logic                        segment_kind,
  input logic [gbn_pkg::OFS_W-1:0]   segment_offset,
  input logic [gbn_pkg::LEN_W-1:0]   segment_length,
  input logic                        transmitted
);

  // Backpressure on input only while results wait at the output
  a_ready_low_has_result: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> desc_valid)
    else $error("cmd stalled with no result pending");

  // A transmitted segment must have been emitted
  a_tx_implies_emit: assert property (@(posedge clk) disable iff (rst)
    (desc_valid && transmitted) |-> emitted)
    else $error("transmitted set without emitted");

  // Empty results carry zero descriptor fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (desc_valid && !emitted) |->
      (!segment_kind && segment_offset == '0 && segment_length == '0))
    else $error("non-zero descriptor on empty result");

  // Every emitted segment carries at least one byte
  a_emit_len: assert property (@(posedge clk) disable iff (rst)
    (desc_valid && emitted) |-> (segment_length != '0))
    else $error("emitted segment with zero length");

  // Held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (desc_valid && !desc_ready) |=>
      (desc_valid && $stable(emitted) && $stable(segment_offset)
       && $stable(segment_length)))
    else $error("stalled descriptor changed");

endmodule

bind go_back_n_sender_with_fec_groups gbn_chk u_gbn_chk (
  .clk            (clk),
  .rst            (rst),
  .cmd_ready      (cmd.ready),
  .desc_valid     (desc.valid),
  .desc_ready     (desc.ready),
  .emitted        (desc.emitted),
  .segment_kind   (desc.segment_kind),
  .segment_offset (desc.segment_offset),
  .segment_length (desc.segment_length),
  .transmitted    (desc.transmitted)
);

`default_nettype wire
